[rtl/core/edmr_pkg.sv]
// edmr_pkg: shared widths, constants and types of the distance core
package edmr_pkg;

	// element and arithmetic widths
	localparam int ELEM_W = 16;
	localparam int DIFF_W = ELEM_W + 1;
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int ACC_W  = 45;
	localparam int ROOT_W = (ACC_W + 1) / 2;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 3;
	localparam int ITER_W = $clog2(ROOT_W);

	// job queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

	// mode register reset value: minimum over vector and reflection
	localparam logic MODE_RESET = 1'b1;

	// one finished vector waiting for its square root
	typedef struct packed {
		logic [ACC_W-1:0] sq;
		logic             refl;
	} dist_job_t;

	// push side of the job queue
	typedef struct packed {
		logic      vld;
		dist_job_t job;
	} queue_push_t;

endpackage

[rtl/core/edmr_if.sv]
// edmr_if: valid/ready channel interfaces for element pairs and distance results
interface edmr_in_if
	import edmr_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic signed [ELEM_W-1:0] elem_a;
	logic signed [ELEM_W-1:0] elem_b;
	logic                     last_element;

	modport source (output valid, output elem_a, output elem_b, output last_element,
		input ready);
	modport sink (input valid, input elem_a, input elem_b, input last_element,
		output ready);
endinterface

interface edmr_out_if
	import edmr_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [ROOT_W-1:0] distance;
	logic [ACC_W-1:0]  distance_sq;
	logic              reflected_chosen;

	modport source (output valid, output distance, output distance_sq,
		output reflected_chosen, input ready);
	modport sink (input valid, input distance, input distance_sq,
		input reflected_chosen, output ready);
endinterface

[rtl/core/edmr_front.sv]
// edmr_front: accepts element pairs, squares and accumulates, classifies direct vs reflected
module edmr_front
	import edmr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	edmr_in_if.sink           sample,
	input  logic              mode,
	input  logic [QCNT_W-1:0] q_used,
	output queue_push_t       push
);

	logic                     vld_s1, last_s1;
	logic [DIFF_W-1:0]        dmag_s1, rmag_s1;
	logic                     vld_s2, last_s2;
	logic [SQ_W-1:0]          dsq_s2, rsq_s2;
	logic                     vld_s3;
	logic [ACC_W-1:0]         accd_s3, accr_s3;
	logic [ACC_W-1:0]         acc_d_q, acc_r_q;

	logic                     take;
	logic [QCNT_W:0]          inflight;
	logic signed [DIFF_W-1:0] diff, sum;
	logic [DIFF_W-1:0]        dmag, rmag;
	logic [ACC_W:0]           dsum, rsum;
	logic [ACC_W-1:0]         dnext, rnext;
	logic                     refl;

	// room check: every last in flight must find a queue slot
	assign inflight = (QCNT_W+1)'(vld_s1 & last_s1) + (QCNT_W+1)'(vld_s2 & last_s2)
		+ (QCNT_W+1)'(vld_s3);
	assign sample.ready = ({1'b0, q_used} + inflight) < (QCNT_W+1)'(QUEUE_DEPTH);
	assign take = sample.valid & sample.ready;

	// difference, sum and their magnitudes
	always_comb begin
		diff = DIFF_W'(sample.elem_a) - DIFF_W'(sample.elem_b);
		sum  = DIFF_W'(sample.elem_a) + DIFF_W'(sample.elem_b);
		dmag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		rmag = sum[DIFF_W-1] ? DIFF_W'(-sum) : DIFF_W'(sum);
	end

	// saturating accumulate of the squared terms
	always_comb begin
		dsum  = {1'b0, acc_d_q} + (ACC_W+1)'(dsq_s2);
		rsum  = {1'b0, acc_r_q} + (ACC_W+1)'(rsq_s2);
		dnext = (dsum >= {1'b0, ACC_MAX}) ? ACC_MAX : dsum[ACC_W-1:0];
		rnext = (rsum >= {1'b0, ACC_MAX}) ? ACC_MAX : rsum[ACC_W-1:0];
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			acc_d_q <= '0;
			acc_r_q <= '0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2 & last_s2;
			if (vld_s2) begin
				if (last_s2) begin
					acc_d_q <= '0;
					acc_r_q <= '0;
				end else begin
					acc_d_q <= dnext;
					acc_r_q <= rnext;
				end
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		dmag_s1 <= dmag;
		rmag_s1 <= rmag;
		last_s1 <= sample.last_element;
		dsq_s2  <= SQ_W'(dmag_s1) * SQ_W'(dmag_s1);
		rsq_s2  <= SQ_W'(rmag_s1) * SQ_W'(rmag_s1);
		last_s2 <= last_s1;
		accd_s3 <= dnext;
		accr_s3 <= rnext;
	end

	// with mode set, pick the smaller sum, reflected wins a tie; else the direct sum
	assign refl = mode & ~(accd_s3 < accr_s3);
	assign push.vld      = vld_s3;
	assign push.job.refl = refl;
	assign push.job.sq   = refl ? accr_s3 : accd_s3;

endmodule

[rtl/core/edmr_queue.sv]
// edmr_queue: short job queue between accumulation front and square root back
module edmr_queue
	import edmr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  queue_push_t       push,
	input  logic              pop,
	output logic              head_vld,
	output dist_job_t         head,
	output logic [QCNT_W-1:0] used
);

	dist_job_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign head_vld = cnt_q != '0;
	assign head     = mem_q[rd_ptr_q];
	assign used     = cnt_q;
	assign do_pop   = pop & head_vld;

	// storage
	always_ff @(posedge clk) begin
		if (push.vld) begin
			mem_q[wr_ptr_q] <= push.job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.vld) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push.vld && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push.vld && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/edmr_back.sv]
// edmr_back: bit-serial floor square root and result register
module edmr_back
	import edmr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_vld,
	input  dist_job_t  head,
	output logic       pop,
	edmr_out_if.source result
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]        state_q;
	logic [ITER_W-1:0] iter_q;
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [ACC_W-1:0]  sq_q;
	logic              refl_q;
	logic              out_vld_q;
	logic [ROOT_W-1:0] out_dist_q;
	logic [ACC_W-1:0]  out_sq_q;
	logic              out_refl_q;

	logic [REM_W-1:0]  rem_sh, trial;
	logic              fits;
	logic              load_out;

	assign pop      = (state_q == ST_IDLE) & head_vld;
	assign load_out = (state_q == ST_DONE) & (~out_vld_q | result.ready);

	// one root bit per cycle: bring down two radicand bits and try
	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
		trial  = REM_W'({root_q, 2'b01});
		fits   = rem_sh >= trial;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (head_vld) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (iter_q == ITER_W'(ROOT_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (pop) begin
			rad_q  <= RAD_W'(head.sq);
			sq_q   <= head.sq;
			refl_q <= head.refl;
			rem_q  <= '0;
			root_q <= '0;
			iter_q <= '0;
		end else if (state_q == ST_RUN) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			iter_q <= iter_q + 1'b1;
			if (fits) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (load_out) begin
			out_dist_q <= root_q;
			out_sq_q   <= sq_q;
			out_refl_q <= refl_q;
		end
	end

	assign result.valid            = out_vld_q;
	assign result.distance         = out_dist_q;
	assign result.distance_sq      = out_sq_q;
	assign result.reflected_chosen = out_refl_q;

endmodule

[rtl/core/euclidean_distance_mod_reflection_core.sv]
// Top level: one element pair per cycle while the job queue has room for every vector in
// flight; three accumulate stages feed a 4-entry job queue. Each vector passes through the
// 3 accumulate stages, a queue write, the pop, 23 square root steps and an output register
// load. The square root unit takes one job at a time and pops the next only after loading
// its result, so short vectors stall input once the queue fills.
// Reset (arst_n low) clears accumulators, queue, sequencer and output valid; mode resets to 1.
module euclidean_distance_mod_reflection_core
	import edmr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	edmr_in_if.sink    sample,
	edmr_out_if.source result
);

	logic              mode_q;
	queue_push_t       push;
	logic [QCNT_W-1:0] q_used;
	logic              head_vld;
	dist_job_t         head;
	logic              pop;

	// distance mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	// accumulate and classify
	edmr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.mode   (mode_q),
		.q_used (q_used),
		.push   (push)
	);

	// finished vectors waiting for the root unit
	edmr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (pop),
		.head_vld (head_vld),
		.head     (head),
		.used     (q_used)
	);

	// square root and output register
	edmr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_vld (head_vld),
		.head     (head),
		.pop      (pop),
		.result   (result)
	);

endmodule

[dv/tb_euclidean_distance_mod_reflection_core.sv]
// tb_euclidean_distance_mod_reflection_core: self-checking bench for the streamed distance core
module tb_euclidean_distance_mod_reflection_core;
	timeunit 1ns;
	timeprecision 1ps;
	import edmr_pkg::*;

	localparam logic MODE_PLAIN   = 1'b0;
	localparam logic MODE_MIN_REF = 1'b1;
	localparam int   SETTLE_CYC   = 40;
	localparam int   HOLD_CYC     = 400;
	localparam int   RAND_PAIRS   = 1650;

	typedef enum {RX_OPEN, RX_BUSY, RX_CHOKE, RX_PERIODIC} rx_pattern_t;
	typedef enum {VK_RANDOM, VK_TIE, VK_NEAR, VK_ANTI, VK_EXTREME} vec_kind_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] a;
		logic signed [ELEM_W-1:0] b;
		logic                     last;
	} pair_t;

	typedef struct packed {
		logic [ROOT_W-1:0] distance;
		logic [ACC_W-1:0]  sq;
		logic              refl;
	} dist_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en;
	logic cfg_wr_data;

	edmr_in_if  sample_if ();
	edmr_out_if result_if ();

	euclidean_distance_mod_reflection_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.sample      (sample_if),
		.result      (result_if)
	);

	// predictor state and expected results
	logic [ACC_W-1:0] acc_direct_m;
	logic [ACC_W-1:0] acc_reflect_m;
	logic             dist_mode_m;
	pair_t            pair_pending[$];
	dist_res_t        dist_expected[$];

	// run bookkeeping
	int pairs_queued = 0;
	int pairs_accepted = 0;
	int vectors_queued = 0;
	int results_seen = 0;
	int refl_seen = 0;
	int sat_seen = 0;
	int mode_writes = 0;
	int mismatch_count = 0;

	// sender and receiver pacing knobs
	int          tx_gap_max = 0;
	int          tx_gap_left = 0;
	int          tx_burst_left = 0;
	rx_pattern_t rx_mode = RX_OPEN;
	int          hold_req_id = 0;
	int          hold_seen_id = 0;
	int          hold_left = 0;
	int          rx_tick = 0;
	pair_t       nxt_pair;
	dist_res_t   got_res;
	dist_res_t   want_res;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// saturating add of one squared term
	function automatic logic [ACC_W-1:0] sat_acc(input logic [ACC_W-1:0] acc,
		input logic [63:0] term);
		logic [63:0] s;
		s = 64'(acc) + term;
		return (s >= 64'(ACC_MAX)) ? ACC_MAX : s[ACC_W-1:0];
	endfunction

	// floor square root, one result bit per step from the top
	function automatic logic [ROOT_W-1:0] isqrt(input logic [ACC_W-1:0] v);
		logic [63:0] root;
		logic [63:0] trial;
		root = 64'd0;
		for (int i = ROOT_W - 1; i >= 0; i--) begin
			trial = root | (64'd1 << i);
			if (trial * trial <= 64'(v))
				root = trial;
		end
		return root[ROOT_W-1:0];
	endfunction

	// fold one accepted pair into the accumulators, emit a result on last
	task automatic absorb_pair(input pair_t p);
		logic [DIFF_W-1:0] dif;
		logic [DIFF_W-1:0] sm;
		logic [DIFF_W-1:0] mag_d;
		logic [DIFF_W-1:0] mag_s;
		dist_res_t r;
		dif = {p.a[ELEM_W-1], p.a} - {p.b[ELEM_W-1], p.b};
		sm = {p.a[ELEM_W-1], p.a} + {p.b[ELEM_W-1], p.b};
		mag_d = dif[DIFF_W-1] ? -dif : dif;
		mag_s = sm[DIFF_W-1] ? -sm : sm;
		acc_direct_m = sat_acc(acc_direct_m, 64'(mag_d) * 64'(mag_d));
		acc_reflect_m = sat_acc(acc_reflect_m, 64'(mag_s) * 64'(mag_s));
		if (p.last) begin
			// tie goes to the reflected form
			if (dist_mode_m == MODE_MIN_REF && !(acc_direct_m < acc_reflect_m)) begin
				r.sq = acc_reflect_m;
				r.refl = 1'b1;
			end else begin
				r.sq = acc_direct_m;
				r.refl = 1'b0;
			end
			r.distance = isqrt(r.sq);
			dist_expected.push_back(r);
			acc_direct_m = '0;
			acc_reflect_m = '0;
		end
	endtask

	// sender: bursts of transactions with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			sample_if.valid <= 1'b0;
		end else begin
			if (sample_if.valid && sample_if.ready) begin
				absorb_pair({sample_if.elem_a, sample_if.elem_b, sample_if.last_element});
				pairs_accepted++;
			end
			if (!sample_if.valid || sample_if.ready) begin
				if (tx_gap_left > 0) begin
					tx_gap_left--;
					sample_if.valid <= 1'b0;
				end else if (pair_pending.size() > 0) begin
					nxt_pair = pair_pending.pop_front();
					sample_if.valid <= 1'b1;
					sample_if.elem_a <= nxt_pair.a;
					sample_if.elem_b <= nxt_pair.b;
					sample_if.last_element <= nxt_pair.last;
					if (tx_burst_left > 0) begin
						tx_burst_left--;
					end else begin
						tx_burst_left = $urandom_range(0, 15);
						tx_gap_left = $urandom_range(0, tx_gap_max);
					end
				end else begin
					sample_if.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern plus an occasional long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
		end else if (hold_req_id != hold_seen_id) begin
			hold_seen_id = hold_req_id;
			hold_left = HOLD_CYC;
			result_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			result_if.ready <= 1'b0;
		end else begin
			rx_tick++;
			case (rx_mode)
				RX_OPEN: result_if.ready <= 1'b1;
				RX_BUSY: result_if.ready <= ($urandom_range(0, 9) < 7);
				RX_CHOKE: result_if.ready <= ($urandom_range(0, 9) < 2);
				default: result_if.ready <= ((rx_tick % 11) < 4);
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) begin
			got_res = {result_if.distance, result_if.distance_sq, result_if.reflected_chosen};
			results_seen++;
			if (dist_expected.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: result with nothing expected: dist=%0d sq=%0d refl=%0b",
						$realtime, got_res.distance, got_res.sq, got_res.refl);
			end else begin
				want_res = dist_expected.pop_front();
				if (got_res !== want_res) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: mismatch exp dist=%0d sq=%0d refl=%0b, got dist=%0d sq=%0d refl=%0b",
							$realtime, want_res.distance, want_res.sq, want_res.refl,
							got_res.distance, got_res.sq, got_res.refl);
				end
				if (want_res.refl)
					refl_seen++;
				if (want_res.sq == ACC_MAX)
					sat_seen++;
			end
		end
	end

	task automatic push_pair(input logic signed [ELEM_W-1:0] a,
		input logic signed [ELEM_W-1:0] b, input logic last);
		pair_pending.push_back({a, b, last});
		pairs_queued++;
		if (last)
			vectors_queued++;
	endtask

	function automatic logic signed [ELEM_W-1:0] extreme_val();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh8001;
			2: return -16'sd1;
			3: return 16'sd0;
			4: return 16'sd1;
			default: return 16'sh7fff;
		endcase
	endfunction

	// one vector of a given flavor; with_last=0 leaves it open
	task automatic push_vector(input int len, input vec_kind_t k, input logic with_last);
		logic signed [ELEM_W-1:0] a;
		logic signed [ELEM_W-1:0] b;
		logic signed [ELEM_W-1:0] jit;
		for (int i = 0; i < len; i++) begin
			a = 16'($urandom);
			b = 16'($urandom);
			jit = 16'($urandom_range(0, 64)) - 16'sd32;
			case (k)
				VK_TIE: begin
					if ($urandom_range(0, 1))
						b = '0;
					else
						a = '0;
				end
				VK_NEAR: b = a + jit;
				VK_ANTI: b = -a + jit;
				VK_EXTREME: begin
					a = extreme_val();
					b = extreme_val();
				end
				default: ;
			endcase
			push_pair(a, b, with_last && (i == len - 1));
		end
	endtask

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 6);
		else if (r < 95)
			return $urandom_range(7, 40);
		return $urandom_range(41, 200);
	endfunction

	// wait until everything sent has been answered, then let the core drain
	task automatic settle();
		while (pairs_accepted != pairs_queued || dist_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		dist_mode_m = m;
		mode_writes++;
	endtask

	// stimulus sequence
	initial begin
		int rand_pairs;
		int len;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		sample_if.valid = 1'b0;
		sample_if.elem_a = '0;
		sample_if.elem_b = '0;
		sample_if.last_element = 1'b0;
		result_if.ready = 1'b0;
		acc_direct_m = '0;
		acc_reflect_m = '0;
		dist_mode_m = MODE_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: extremes, ties, both modes, mode change inside a vector
		tx_gap_max = 3;
		rx_mode = RX_BUSY;
		push_pair(16'sh7fff, 16'sh8000, 1'b1);
		push_pair(16'sh8000, 16'sh8000, 1'b1);
		push_pair(16'sd0, 16'sd0, 1'b1);
		push_pair(16'sh8000, 16'sh7fff, 1'b1);
		push_pair(16'sh7fff, 16'sh7fff, 1'b1);
		push_pair(16'sd3, 16'sd0, 1'b1);
		push_pair(16'sh8000, 16'sd0, 1'b0);
		push_pair(16'sd0, 16'sh8000, 1'b0);
		push_pair(16'sd7, -16'sd7, 1'b1);
		push_pair(16'sd1, 16'sd2, 1'b0);
		push_pair(16'sd100, -16'sd100, 1'b0);
		settle();
		write_mode(MODE_PLAIN);
		push_pair(-16'sd1, 16'sd1, 1'b1);
		push_pair(16'sh7fff, 16'sh8000, 1'b1);
		push_pair(16'sd0, 16'sd0, 1'b1);
		push_pair(16'sh8000, 16'sh8000, 1'b1);
		push_pair(16'sd5, -16'sd5, 1'b1);
		push_pair(-16'sd12345, 16'sd23456, 1'b0);
		push_pair(16'sh7fff, 16'sh7fff, 1'b1);
		push_pair(16'sd10, 16'sd20, 1'b0);
		settle();
		write_mode(MODE_MIN_REF);
		push_pair(16'sd30, -16'sd40, 1'b1);
		settle();
		write_mode(MODE_MIN_REF);

		// long receiver hold-off while the sender keeps offering short vectors
		tx_gap_max = 0;
		rx_mode = RX_OPEN;
		hold_req_id++;
		for (int i = 0; i < 40; i++)
			push_vector($urandom_range(1, 2), vec_kind_t'($urandom_range(0, 4)), 1'b1);
		settle();

		// random phases with changing mode and pacing
		rand_pairs = 0;
		for (int ph = 0; rand_pairs < RAND_PAIRS; ph++) begin
			settle();
			write_mode((ph % 2 == 0) ? MODE_PLAIN : MODE_MIN_REF);
			rx_mode = rx_pattern_t'(ph % 4);
			tx_gap_max = (ph % 3 == 0) ? 0 : $urandom_range(1, 12);
			for (int n = 0; n < 200; n += len) begin
				len = pick_len();
				push_vector(len, vec_kind_t'($urandom_range(0, 4)), 1'b1);
				rand_pairs += len;
			end
			// sometimes leave a vector open across the mode write
			if ($urandom_range(0, 2) == 0) begin
				len = $urandom_range(1, 5);
				push_vector(len, vec_kind_t'($urandom_range(0, 4)), 1'b0);
				rand_pairs += len;
			end
		end
		settle();

		if (dist_expected.size() != 0)
			mismatch_count++;
		$display("run covered %0d element pairs in %0d vectors, %0d mode writes",
			pairs_accepted, vectors_queued, mode_writes);
		$display("results: %0d checked, %0d reflected, %0d saturated, %0d mismatches",
			results_seen, refl_seen, sat_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
